// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the register ALU.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/ralu_pkg.sv =====
// Package for the register ALU: beat types, decoded item type, codes and helpers.
// Used by every module of the block; depends on nothing.
package ralu_pkg;

	localparam int WORD_W    = 64;
	localparam int HALF_W    = 32;
	localparam int REG_IDX_W = 5;
	localparam int AMT_W     = 6;

	// Instruction field positions.
	localparam int WIDE_BIT = 31;
	localparam int MUL_BIT  = 28;
	localparam int SUB_BIT  = 15;

	typedef struct packed {
		logic [31:0]       instruction_word;
		logic [WORD_W-1:0] first_source_value;
		logic [WORD_W-1:0] second_source_value;
		logic [WORD_W-1:0] accumulate_value;
	} in_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] dest_index;
		logic [WORD_W-1:0]    result_value;
		logic                 flags_written;
		logic                 flag_negative;
		logic                 flag_zero;
		logic                 flag_carry;
		logic                 flag_overflow;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOGIC,
		OP_ARITH,
		OP_MUL
	} op_class_t;

	typedef enum logic [1:0] {
		SH_LSL,
		SH_LSR,
		SH_ASR,
		SH_ROR
	} shift_t;

	typedef enum logic [1:0] {
		LG_AND,
		LG_ORR,
		LG_EOR,
		LG_ANDS
	} logic_op_t;

	// One classified instruction as it waits in the queue.
	typedef struct packed {
		op_class_t            op_class;
		logic                 wide;
		logic                 sub;
		logic                 set_flags;
		shift_t               shift;
		logic [AMT_W-1:0]     amount;
		logic                 invert;
		logic_op_t            lop;
		logic [REG_IDX_W-1:0] rd;
		logic [WORD_W-1:0]    a;
		logic [WORD_W-1:0]    b;
		logic [WORD_W-1:0]    acc;
	} decoded_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// All ones at the operating width.
	function automatic logic [WORD_W-1:0] width_mask(logic wide);
		return wide ? {WORD_W{1'b1}} : {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
	endfunction

	// Sign bit of a value at the operating width.
	function automatic logic top_bit(logic [WORD_W-1:0] v, logic wide);
		return wide ? v[WORD_W-1] : v[HALF_W-1];
	endfunction

endpackage

// ===== hw/rtl/ralu_front.sv =====
// Front end of the register ALU: accepts instruction beats, decodes and classifies them.
// Depends on ralu_pkg; feeds the instruction queue.
module ralu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                instr_valid,
	output logic                instr_stall,
	input  ralu_pkg::in_item_t  instr_data,
	input  ralu_pkg::q_status_t q_status,
	output logic                push,
	output ralu_pkg::decoded_t  push_data
);

	logic               dec_valid_q;
	ralu_pkg::decoded_t dec_q;
	ralu_pkg::decoded_t dec_next;
	logic               accept;

	// Decode the instruction word and trim the operands to the operating width.
	always_comb begin
		logic [31:0]              iw;
		logic                     wide;
		logic [1:0]               opc;
		logic [3:0]               opr;
		logic [5:0]               imm6;
		logic [ralu_pkg::WORD_W-1:0] mask;
		iw   = instr_data.instruction_word;
		wide = iw[ralu_pkg::WIDE_BIT];
		opc  = iw[30:29];
		opr  = iw[24:21];
		imm6 = iw[15:10];
		mask = ralu_pkg::width_mask(wide);
		if (iw[ralu_pkg::MUL_BIT]) begin
			dec_next.op_class = ralu_pkg::OP_MUL;
		end else if (opr[3]) begin
			dec_next.op_class = ralu_pkg::OP_ARITH;
		end else begin
			dec_next.op_class = ralu_pkg::OP_LOGIC;
		end
		dec_next.wide = wide;
		dec_next.sub = iw[ralu_pkg::MUL_BIT] ? iw[ralu_pkg::SUB_BIT] : opc[1];
		dec_next.set_flags = !iw[ralu_pkg::MUL_BIT] &&
			((opr[3] && opc[0]) ||
			(!opr[3] && ralu_pkg::logic_op_t'(opc) == ralu_pkg::LG_ANDS));
		dec_next.shift = ralu_pkg::shift_t'(opr[2:1]);
		dec_next.amount = wide ? imm6 : {1'b0, imm6[4:0]};
		dec_next.invert = opr[0];
		dec_next.lop = ralu_pkg::logic_op_t'(opc);
		dec_next.rd = iw[ralu_pkg::REG_IDX_W-1:0];
		dec_next.a = instr_data.first_source_value & mask;
		dec_next.b = instr_data.second_source_value & mask;
		dec_next.acc = instr_data.accumulate_value & mask;
	end

	// The decode register empties into the queue whenever there is room.
	assign push        = dec_valid_q && !q_status.full;
	assign instr_stall = dec_valid_q && q_status.full;
	assign accept      = instr_valid && !instr_stall;
	assign push_data   = dec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid_q <= 1'b0;
		end else if (accept) begin
			dec_valid_q <= 1'b1;
		end else if (push) begin
			dec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q <= dec_next;
		end
	end

endmodule

// ===== hw/rtl/ralu_queue.sv =====
// Short queue of decoded instructions between the front and the back end.
// Depends on ralu_pkg; depth is set by the DEPTH parameter.
module ralu_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ralu_pkg::decoded_t  push_data,
	input  logic                pop,
	output ralu_pkg::decoded_t  pop_data,
	output ralu_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CT = CNT_W'(DEPTH);

	ralu_pkg::decoded_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == FULL_CT);
	assign status.empty = (count_q == '0);
	assign pop_data     = entry_q[rd_ptr_q];

	// Pointers wrap at the last entry; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/ralu_back.sv =====
// Back end of the register ALU: three-stage execute pipeline with a split multiplier.
// Depends on ralu_pkg; takes decoded instructions from the queue.
module ralu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ralu_pkg::q_status_t q_status,
	output logic                pop,
	input  ralu_pkg::decoded_t  pop_data,
	output logic                res_valid,
	input  logic                res_stall,
	output ralu_pkg::out_item_t res_data
);

	localparam int W = ralu_pkg::WORD_W;
	localparam int H = ralu_pkg::HALF_W;

	logic advance;

	// Stage 1 registers.
	logic                              v_s1;
	ralu_pkg::op_class_t               cls_s1;
	logic                              wide_s1;
	logic                              sub_s1;
	logic                              fw_s1;
	ralu_pkg::logic_op_t               lop_s1;
	logic [ralu_pkg::REG_IDX_W-1:0]    rd_s1;
	logic [W-1:0]                      a_s1;
	logic [W-1:0]                      opnd_s1;
	logic [W-1:0]                      acc_s1;
	logic [W-1:0]                      p0_s1;
	logic [H-1:0]                      p1_s1;
	logic [H-1:0]                      p2_s1;

	// Stage 2 registers.
	logic                              v_s2;
	ralu_pkg::op_class_t               cls_s2;
	logic                              wide_s2;
	logic                              sub_s2;
	logic                              fw_s2;
	logic                              fc_s2;
	logic                              fv_s2;
	logic [ralu_pkg::REG_IDX_W-1:0]    rd_s2;
	logic [W-1:0]                      val_s2;
	logic [W-1:0]                      acc_s2;

	// Stage 3 is the output register.
	logic                              v_s3;
	ralu_pkg::out_item_t               out_s3;

	logic [W-1:0] opnd_c;
	logic [W-1:0] p0_c;
	logic [H-1:0] p1_c;
	logic [H-1:0] p2_c;
	logic [W-1:0] val_c;
	logic         fc_c;
	logic         fv_c;
	ralu_pkg::out_item_t out_c;

	// The whole pipeline holds while a finished result is stalled.
	assign advance   = !(v_s3 && res_stall);
	assign pop       = advance && !q_status.empty;
	assign res_valid = v_s3;
	assign res_data  = out_s3;

	// Stage 1: barrel shift of the second operand, inversion, partial products.
	always_comb begin
		logic [W-1:0]   mask;
		logic [W-1:0]   v;
		logic [W-1:0]   ext;
		logic [2*W-1:0] dbl;
		logic [2*W-1:0] rot;
		logic [W-1:0]   sh;
		logic [W-1:0]   bm;
		logic           inv;
		logic [H-1:0]   a_lo;
		logic [H-1:0]   a_hi;
		logic [H-1:0]   b_lo;
		logic [H-1:0]   b_hi;
		mask = ralu_pkg::width_mask(pop_data.wide);
		v    = pop_data.b;
		ext  = pop_data.wide ? v : {{(W-H){v[H-1]}}, v[H-1:0]};
		dbl  = pop_data.wide ? {v, v} : {{W{1'b0}}, v[H-1:0], v[H-1:0]};
		rot  = dbl >> pop_data.amount;
		case (pop_data.shift)
			ralu_pkg::SH_LSL: sh = v << pop_data.amount;
			ralu_pkg::SH_LSR: sh = v >> pop_data.amount;
			ralu_pkg::SH_ASR: sh = $unsigned($signed(ext) >>> pop_data.amount);
			ralu_pkg::SH_ROR: sh = rot[W-1:0];
			default:          sh = v;
		endcase
		bm = sh & mask;
		if (pop_data.op_class == ralu_pkg::OP_ARITH) begin
			inv = pop_data.sub;
		end else begin
			inv = pop_data.invert;
		end
		opnd_c = inv ? (~bm & mask) : bm;
		a_lo = pop_data.a[H-1:0];
		a_hi = pop_data.a[W-1:H];
		b_lo = pop_data.b[H-1:0];
		b_hi = pop_data.b[W-1:H];
		p0_c = a_lo * b_lo;
		p1_c = a_lo * b_hi;
		p2_c = a_hi * b_lo;
	end

	// Stage 2: add or subtract with flags, logic operation, or product assembly.
	always_comb begin
		logic [W:0]   sum;
		logic [W-1:0] mask;
		logic [W-1:0] res;
		logic [W-1:0] ovx;
		logic [H-1:0] mid_sum;
		mask    = ralu_pkg::width_mask(wide_s1);
		sum     = {1'b0, a_s1} + {1'b0, opnd_s1} + {{W{1'b0}}, sub_s1};
		res     = sum[W-1:0] & mask;
		ovx     = (a_s1 ^ res) & (opnd_s1 ^ res);
		mid_sum = p1_s1 + p2_s1;
		fc_c    = 1'b0;
		fv_c    = 1'b0;
		case (cls_s1)
			ralu_pkg::OP_ARITH: begin
				val_c = res;
				if (fw_s1) begin
					fc_c = wide_s1 ? sum[W] : sum[H];
					fv_c = ralu_pkg::top_bit(ovx, wide_s1);
				end
			end
			ralu_pkg::OP_MUL: begin
				val_c = p0_s1 + {mid_sum, {H{1'b0}}};
			end
			default: begin
				case (lop_s1)
					ralu_pkg::LG_ORR: val_c = a_s1 | opnd_s1;
					ralu_pkg::LG_EOR: val_c = a_s1 ^ opnd_s1;
					default:          val_c = a_s1 & opnd_s1;
				endcase
			end
		endcase
	end

	// Stage 3: accumulate for multiplies, then N and Z at the operating width.
	always_comb begin
		logic [W-1:0] fin;
		if (cls_s2 == ralu_pkg::OP_MUL) begin
			fin = (sub_s2 ? (acc_s2 - val_s2) : (acc_s2 + val_s2)) &
				ralu_pkg::width_mask(wide_s2);
		end else begin
			fin = val_s2;
		end
		out_c.dest_index    = rd_s2;
		out_c.result_value  = fin;
		out_c.flags_written = fw_s2;
		out_c.flag_negative = fw_s2 && ralu_pkg::top_bit(fin, wide_s2);
		out_c.flag_zero     = fw_s2 && (fin == '0);
		out_c.flag_carry    = fc_s2;
		out_c.flag_overflow = fv_s2;
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s1  <= pop_data.op_class;
			wide_s1 <= pop_data.wide;
			sub_s1  <= pop_data.sub;
			fw_s1   <= pop_data.set_flags;
			lop_s1  <= pop_data.lop;
			rd_s1   <= pop_data.rd;
			a_s1    <= pop_data.a;
			opnd_s1 <= opnd_c;
			acc_s1  <= pop_data.acc;
			p0_s1   <= p0_c;
			p1_s1   <= p1_c;
			p2_s1   <= p2_c;

			cls_s2  <= cls_s1;
			wide_s2 <= wide_s1;
			sub_s2  <= sub_s1;
			fw_s2   <= fw_s1;
			fc_s2   <= fc_c;
			fv_s2   <= fv_c;
			rd_s2   <= rd_s1;
			val_s2  <= val_c;
			acc_s2  <= acc_s1;

			out_s3  <= out_c;
		end
	end

endmodule

// ===== hw/rtl/arm64_register_alu_execute.sv =====
// Register-form ALU execute unit: one instruction per cycle when the result side does not stall.
// An accepted instruction beat passes through the decode register, the queue, then three execute
// stages before its result appears; the 64-bit multiply is split into 32-bit partial products
// over the first two stages, which sets the pipeline depth.
// Reset clears the valid bits and the queue pointers; no result is offered after reset.
module arm64_register_alu_execute #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                instr_valid,
	output logic                instr_stall,
	input  ralu_pkg::in_item_t  instr_data,
	output logic                res_valid,
	input  logic                res_stall,
	output ralu_pkg::out_item_t res_data
);

	ralu_pkg::q_status_t q_status;
	ralu_pkg::decoded_t  push_data;
	ralu_pkg::decoded_t  pop_data;
	logic                push;
	logic                pop;

	// Decode and classify.
	ralu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr_data  (instr_data),
		.q_status    (q_status),
		.push        (push),
		.push_data   (push_data)
	);

	// Decouple the two sides.
	ralu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// Execute.
	ralu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop       (pop),
		.pop_data  (pop_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== hw/rtl/ralu_checker.sv =====
// Port-level checker for the register ALU, bound to the top level.
// Depends on ralu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ralu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                instr_valid,
	input logic                instr_stall,
	input ralu_pkg::in_item_t  instr_data,
	input logic                res_valid,
	input logic                res_stall,
	input ralu_pkg::out_item_t res_data
);

	logic stalled_beat;
	logic any_flag;
	logic zero_ok;
	logic sign_set;

	// Conditions on the result beat that the assertions refer to.
	assign stalled_beat = res_valid && res_stall;
	assign any_flag     = res_data.flag_negative || res_data.flag_zero ||
		res_data.flag_carry || res_data.flag_overflow;
	assign zero_ok      = (res_data.result_value == '0) && !res_data.flag_negative;
	assign sign_set     = res_data.result_value[63] || res_data.result_value[31];

	// A stalled result beat stays offered and unchanged.
	`ASSERT_NEXT(a_res_hold, stalled_beat, res_valid && $stable(res_data), "stalled beat changed")

	// Flags are all clear unless the operation writes them.
	`ASSERT_IMPLY(a_flags_clear, res_valid && !res_data.flags_written, !any_flag, "stray flag")

	// A zero flag means a zero result and a clear sign.
	`ASSERT_IMPLY(a_zero_result, res_valid && res_data.flag_zero, zero_ok, "zero flag wrong")

	// A set N flag implies that bit 63 or bit 31 of the result is set, the sign bit at either width.
	`ASSERT_IMPLY(a_neg_result, res_valid && res_data.flag_negative, sign_set, "sign flag wrong")

endmodule

bind arm64_register_alu_execute ralu_checker u_checker (.*);

// ===== tb/arm64_register_alu_execute_checker.sv =====
// Result checker for the register-form ALU execute unit: predicts each result from the
// accepted instruction beat and compares it with the result beat. Depends on ralu_pkg.
module arm64_register_alu_execute_checker
	import ralu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      instr_valid,
	input  logic      instr_stall,
	input  in_item_t  instr_data,
	input  logic      res_valid,
	input  logic      res_stall,
	input  out_item_t res_data,
	output int        fail_count,
	output int        pending,
	output int        checked
);

	// Instruction bits that the package does not name.
	localparam int OPC_SUB_BIT = 30;
	localparam int OPC_SET_BIT = 29;
	localparam int ARITH_BIT   = 24;
	localparam int INVERT_BIT  = 21;

	out_item_t expected_results[$];

	initial begin
		fail_count = 0;
		pending    = 0;
		checked    = 0;
	end

	// Shifts the second operand at the operating width; the amount wraps at the width.
	function automatic logic [63:0] barrel_shift(logic [63:0] v, shift_t kind,
			logic [5:0] amount, logic wide);
		logic [63:0] mask;
		logic [63:0] r;
		int          w;
		int          n;
		w    = wide ? 64 : 32;
		mask = wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
		n    = amount & (w - 1);
		v    = v & mask;
		if (n == 0)
			return v;
		case (kind)
			SH_LSL: r = v << n;
			SH_LSR: r = v >> n;
			SH_ASR: begin
				r = v >> n;
				if (v[w-1])
					r = r | (mask & ~(mask >> n));
			end
			default: r = (v >> n) | (v << (w - n));
		endcase
		return r & mask;
	endfunction

	// Works out the result beat that one instruction beat should produce.
	function automatic out_item_t execute_instruction(in_item_t it);
		logic [31:0] iw;
		logic        wide;
		logic [63:0] mask;
		logic [63:0] sign_mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] acc;
		logic [63:0] bm;
		logic [63:0] rhs;
		logic [63:0] res;
		logic [64:0] sum;
		out_item_t   r;
		iw        = it.instruction_word;
		wide      = iw[WIDE_BIT];
		mask      = wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
		sign_mask = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		a         = it.first_source_value & mask;
		b         = it.second_source_value & mask;
		r         = '0;
		r.dest_index = iw[4:0];

		// Multiply-add and multiply-subtract never touch the flags.
		if (iw[MUL_BIT]) begin
			acc = it.accumulate_value & mask;
			res = iw[SUB_BIT] ? acc - a * b : acc + a * b;
			r.result_value = res & mask;
			return r;
		end

		bm = barrel_shift(b, shift_t'(iw[23:22]), iw[15:10], wide);
		if (iw[ARITH_BIT]) begin
			// Subtraction is addition of the inverted operand plus one.
			rhs = iw[OPC_SUB_BIT] ? (~bm & mask) : bm;
			sum = {1'b0, a} + {1'b0, rhs} + 65'(iw[OPC_SUB_BIT]);
			res = sum[63:0] & mask;
			if (iw[OPC_SET_BIT]) begin
				r.flags_written = 1'b1;
				r.flag_carry    = wide ? sum[64] : sum[32];
				r.flag_overflow = |((a ^ res) & (rhs ^ res) & sign_mask);
			end
		end else begin
			if (iw[INVERT_BIT])
				bm = ~bm & mask;
			case (logic_op_t'(iw[30:29]))
				LG_AND: res = a & bm;
				LG_ORR: res = a | bm;
				LG_EOR: res = a ^ bm;
				default: begin
					res = a & bm;
					r.flags_written = 1'b1;
				end
			endcase
		end
		r.result_value = res;
		if (r.flags_written) begin
			r.flag_negative = |(res & sign_mask);
			r.flag_zero     = (res == 64'd0);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: result mismatch, %s: got %h, expected %h", $time, what, got, want);
		fail_count = fail_count + 1;
	endtask

	task automatic compare_result(out_item_t got, out_item_t want);
		if (got.dest_index !== want.dest_index)
			report_mismatch("dest_index", 64'(got.dest_index), 64'(want.dest_index));
		if (got.result_value !== want.result_value)
			report_mismatch("result_value", got.result_value, want.result_value);
		if (got.flags_written !== want.flags_written)
			report_mismatch("flags_written", 64'(got.flags_written), 64'(want.flags_written));
		if (got.flag_negative !== want.flag_negative)
			report_mismatch("flag_negative", 64'(got.flag_negative), 64'(want.flag_negative));
		if (got.flag_zero !== want.flag_zero)
			report_mismatch("flag_zero", 64'(got.flag_zero), 64'(want.flag_zero));
		if (got.flag_carry !== want.flag_carry)
			report_mismatch("flag_carry", 64'(got.flag_carry), 64'(want.flag_carry));
		if (got.flag_overflow !== want.flag_overflow)
			report_mismatch("flag_overflow", 64'(got.flag_overflow), 64'(want.flag_overflow));
	endtask

	// Retire the result beat first so that a beat can never be matched with its own instruction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0)
					report_mismatch("beat with no result due", res_data.result_value, 64'd0);
				else begin
					compare_result(res_data, expected_results.pop_front());
					checked = checked + 1;
				end
			end
			if (instr_valid && !instr_stall)
				expected_results.push_back(execute_instruction(instr_data));
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/arm64_register_alu_execute_tb.sv =====
// Testbench top for the register-form ALU execute unit: clock, reset, instruction stimulus,
// random stalls on the result side and the verdict. Depends on ralu_pkg and the checker module.
module arm64_register_alu_execute_tb;
	import ralu_pkg::*;

	typedef enum logic [1:0] {
		ARITH_ADD,
		ARITH_ADDS,
		ARITH_SUB,
		ARITH_SUBS
	} arith_op_t;

	localparam int    RANDOM_COUNT = 1126;
	localparam int    PAUSE_AT     = 500;
	localparam int    QUIET_TAIL   = 150;
	localparam int    SETTLE       = 16;
	localparam int    ARITH_BIT    = 24;
	localparam longint TIME_LIMIT  = 4000000;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      instr_valid = 1'b0;
	logic      instr_stall;
	in_item_t  instr_data  = '0;
	logic      res_valid;
	logic      res_stall   = 1'b0;
	out_item_t res_data;

	int fail_count;
	int pending;
	int checked;
	bit quiet_tail = 1'b0;
	int n_arith    = 0;
	int n_logic    = 0;
	int n_mul      = 0;
	int n_wide     = 0;

	arm64_register_alu_execute dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr_data  (instr_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);

	arm64_register_alu_execute_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr_data  (instr_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The result side stalls in bursts, and not at all towards the end of the run.
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 16);
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		#(TIME_LIMIT);
		$display("Run stopped: time limit reached with %0d results outstanding.", pending);
		$display("arm64_register_alu_execute_tb NOT OK");
		$finish;
	end

	function automatic logic [3:0] shifted_op(logic arith, shift_t sh, logic inv);
		return {arith, sh, inv};
	endfunction

	// Register numbers and the ignored bits 27:25 are always random.
	function automatic logic [31:0] encode(logic wide, logic [1:0] opc, logic mul,
			logic [3:0] opr, logic [5:0] amt);
		logic [14:0] regs;
		regs = 15'($urandom);
		return {wide, opc, mul, 3'($urandom), opr, regs[14:10], amt, regs[9:5], regs[4:0]};
	endfunction

	// Operands lean towards the values where carries, overflow and zero results live.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 10))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return {$urandom, 32'h8000_0000};
			5: return {$urandom, 32'h7FFF_FFFF};
			6: return {$urandom, 32'hFFFF_FFFF};
			7: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t random_instruction();
		in_item_t it;
		it.instruction_word    = encode(1'($urandom), 2'($urandom),
			$urandom_range(0, 4) == 0, 4'($urandom), 6'($urandom));
		it.first_source_value  = pick_operand();
		it.second_source_value = ($urandom_range(0, 7) == 0) ? it.first_source_value
			: pick_operand();
		it.accumulate_value    = pick_operand();
		return it;
	endfunction

	// Offers one instruction beat, sometimes after a gap, and holds it until accepted.
	task automatic send_instruction(in_item_t it);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		instr_valid <= 1'b1;
		instr_data  <= it;
		do
			@(posedge clk);
		while (instr_stall);
		if (it.instruction_word[MUL_BIT])
			n_mul++;
		else if (it.instruction_word[ARITH_BIT])
			n_arith++;
		else
			n_logic++;
		if (it.instruction_word[WIDE_BIT])
			n_wide++;
	endtask

	task automatic drain_results();
		instr_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		logic [63:0] junk;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		junk = {$urandom, $urandom};

		// Carry, overflow and zero at both widths, and borrow at 64 bits.
		send_instruction({encode(1, ARITH_ADDS, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			{64{1'b1}}, 64'd1, junk});
		send_instruction({encode(1, ARITH_ADDS, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			64'h7FFF_FFFF_FFFF_FFFF, 64'd1, junk});
		send_instruction({encode(1, ARITH_SUBS, 0, shifted_op(1, SH_LSR, 0), 6'd0),
			junk, junk, 64'd0});
		send_instruction({encode(1, ARITH_SUBS, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			64'd0, 64'd1, junk});
		send_instruction({encode(1, ARITH_SUBS, 0, shifted_op(1, SH_ASR, 0), 6'd0),
			64'h8000_0000_0000_0000, 64'd1, junk});
		send_instruction({encode(0, ARITH_ADDS, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			{$urandom, 32'hFFFF_FFFF}, {$urandom, 32'h0000_0001}, junk});
		send_instruction({encode(0, ARITH_SUBS, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			{$urandom, 32'h8000_0000}, {$urandom, 32'h0000_0001}, junk});
		send_instruction({encode(0, ARITH_ADDS, 0, shifted_op(1, SH_LSR, 0), 6'd0),
			{$urandom, 32'h7FFF_FFFF}, {$urandom, 32'h0000_0001}, junk});

		// Rotate on add and sub, the invert bit set on arithmetic, amounts past the width.
		send_instruction({encode(1, ARITH_ADD, 0, shifted_op(1, SH_ROR, 1), 6'd8),
			junk, {$urandom, $urandom}, junk});
		send_instruction({encode(0, ARITH_SUB, 0, shifted_op(1, SH_ROR, 1), 6'd37),
			junk, {$urandom, $urandom}, junk});

		// Every logical operation and every shift kind, including the extreme amounts.
		send_instruction({encode(1, LG_AND, 0, shifted_op(0, SH_LSL, 0), 6'd63),
			{64{1'b1}}, {64{1'b1}}, junk});
		send_instruction({encode(1, LG_AND, 0, shifted_op(0, SH_LSR, 1), 6'd1),
			junk, {$urandom, $urandom}, junk});
		send_instruction({encode(1, LG_ORR, 0, shifted_op(0, SH_ASR, 0), 6'd17),
			64'd0, 64'h8000_0000_0000_0000, junk});
		send_instruction({encode(0, LG_ORR, 0, shifted_op(0, SH_ASR, 1), 6'd31),
			junk, {$urandom, 32'h8000_0000}, junk});
		send_instruction({encode(0, LG_EOR, 0, shifted_op(0, SH_ROR, 0), 6'd12),
			junk, {$urandom, $urandom}, junk});
		send_instruction({encode(1, LG_EOR, 0, shifted_op(0, SH_LSL, 1), 6'd0),
			junk, junk, junk});
		send_instruction({encode(1, LG_ANDS, 0, shifted_op(0, SH_LSL, 0), 6'd0),
			64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF, junk});
		send_instruction({encode(0, LG_ANDS, 0, shifted_op(0, SH_LSR, 1), 6'd0),
			{$urandom, 32'hFFFF_FFFF}, {$urandom, 32'h7FFF_FFFF}, junk});

		// Multiply-add and multiply-subtract with random bits where they are ignored.
		send_instruction({encode(1, 2'($urandom), 1, 4'($urandom), {1'b0, 5'($urandom)}),
			{64{1'b1}}, {64{1'b1}}, {64{1'b1}}});
		send_instruction({encode(1, 2'($urandom), 1, 4'($urandom), {1'b1, 5'($urandom)}),
			64'h8000_0000_0000_0000, 64'd3, 64'd0});
		send_instruction({encode(0, 2'($urandom), 1, 4'($urandom), {1'b0, 5'($urandom)}),
			{$urandom, 32'hFFFF_FFFF}, {$urandom, 32'hFFFF_FFFF}, {$urandom, $urandom}});
		send_instruction({encode(0, 2'($urandom), 1, 4'($urandom), {1'b1, 5'($urandom)}),
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, 32'd0}});

		// All-zero operands and a zero arithmetic shift.
		send_instruction({encode(1, ARITH_ADD, 0, shifted_op(1, SH_LSL, 0), 6'd0),
			64'd0, 64'd0, 64'd0});
		send_instruction({encode(1, LG_ORR, 0, shifted_op(0, SH_ASR, 0), 6'd0),
			64'd0, 64'h8000_0000_0000_0001, junk});
		drain_results();

		// Random instructions, with one full drain part-way through.
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == PAUSE_AT)
				drain_results();
			if (i == RANDOM_COUNT - QUIET_TAIL)
				quiet_tail = 1'b1;
			send_instruction(random_instruction());
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d instructions: %0d add/sub, %0d logical, %0d multiply, %0d at 64 bits.",
			n_arith + n_logic + n_mul, n_arith, n_logic, n_mul, n_wide);
		$display("Compared %0d result beats, %0d mismatches.", checked, fail_count);
		if (fail_count == 0)
			$display("arm64_register_alu_execute_tb OK");
		else
			$display("arm64_register_alu_execute_tb NOT OK");
		$finish;
	end

endmodule
